// File: design/satq_pkg.sv
// Shared types and constants of the sorted alarm timer queue.
package satq_pkg;
    localparam int Capacity = 16;
    localparam int SlotW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_REGISTERED = 2'd0;
    localparam logic [1:0] KIND_REFUSED = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;
    localparam logic [1:0] KIND_FIRED = 2'd3;

    typedef struct packed {
        logic [63:0] deadline;
        logic [15:0] tag;
        logic [SlotW-1:0] slot;
    } entry_t;

    // Commands broadcast along the chain for one cycle.
    typedef struct packed {
        logic insert;
        logic remove_head;
        logic remove_slot;
        entry_t ins;
        logic [SlotW-1:0] rm_slot;
    } cmd_t;
endpackage

// File: design/sorted_alarm_timer_queue_unit.sv
// Top level of the sorted alarm timer queue.
//  channel  dir  tuser         tdata (low bit up)                     tlast
//  s_axis   in   op            delay_ms, alarm_tag, cancel_slot       -
//  m_axis   out  result_kind   slot_id, fired_tag, already_gone       last
//  cfg      in   -             tick_period_ms (write enable, data)    -
// Register runs the divider through its 33 steps, waits for its done, then inserts the entry.
// Cancel answers in the cycle after its word is taken; a tick pops each due alarm in
// ST_FIRE and settles tlast in ST_OUT, and a pop waits while a result is still held.
// A result waits in the output register; the next word is taken only once the
// current one has gone. Reset is asynchronous, no clearing pass.
module sorted_alarm_timer_queue_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [55:0] s_axis_tdata, // delay_ms, alarm_tag, cancel_slot
    input  logic [1:0] s_axis_tuser, // op
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [23:0] m_axis_tdata, // slot_id, fired_tag, already_gone
    output logic [1:0] m_axis_tuser, // result_kind
    output logic m_axis_tlast,
    input  logic cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    localparam int SW = satq_pkg::SlotW;
    localparam int CW = satq_pkg::CountW;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV = 3'd1;
    localparam logic [2:0] ST_INS = 3'd2;
    localparam logic [2:0] ST_FIRE = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [15:0] period_reg;
    logic [63:0] count_reg, count_next;
    logic [satq_pkg::Capacity-1:0] busy_reg, busy_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic [15:0] tag_reg, tag_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [4:0] fired_reg, fired_next;
    logic ov_reg, ov_next;
    logic [23:0] od_reg, od_next;
    logic [1:0] okind_reg, okind_next;
    logic ol_reg, ol_next;
    satq_pkg::cmd_t cmd;
    logic head_valid;
    satq_pkg::entry_t head_entry;
    logic div_start, div_done;
    logic [32:0] quot;
    logic [15:0] per;
    logic [32:0] dividend;
    logic [SW-1:0] free_slot;
    logic [1:0] op;
    logic [31:0] delay;
    logic [SW-1:0] cslot;
    logic [32:0] ticks;
    logic accept;
    logic due;

    assign op = s_axis_tuser;
    assign delay = s_axis_tdata[31:0];
    assign cslot = s_axis_tdata[48 +: SW];
    assign per = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign dividend = {1'b0, delay} + {18'd0, per[15:1]};
    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg && (state_reg != ST_OUT);
    assign m_axis_tdata = od_reg;
    assign m_axis_tuser = okind_reg;
    assign m_axis_tlast = ol_reg;
    assign ticks = (quot == 33'd0) ? 33'd1 : quot;
    assign due = head_valid && (head_entry.deadline <= count_reg);

    always_comb
    begin
        free_slot = '0;
        for (int i = satq_pkg::Capacity - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    satq_divider u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(dividend),
        .divisor(per),
        .done(div_done),
        .quotient(quot)
    );

    satq_chain u_chain (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        busy_next = busy_reg;
        pend_next = pend_reg;
        tag_next = tag_reg;
        slot_next = slot_reg;
        fired_next = fired_reg;
        ov_next = ov_reg && !(m_axis_tvalid && m_axis_tready);
        od_next = od_reg;
        okind_next = okind_reg;
        ol_next = ol_reg;
        div_start = 1'b0;
        cmd = '0;
        cmd.ins.deadline = count_reg + {31'd0, ticks};
        cmd.ins.tag = tag_reg;
        cmd.ins.slot = slot_reg;
        cmd.rm_slot = cslot;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        satq_pkg::OP_REGISTER:
                        begin
                            if (delay[31] || pend_reg == CW'(satq_pkg::Capacity))
                            begin
                                ov_next = 1'b1;
                                od_next = 24'd0;
                                okind_next = satq_pkg::KIND_REFUSED;
                                ol_next = 1'b1;
                            end
                            else
                            begin
                                div_start = 1'b1;
                                tag_next = s_axis_tdata[47:32];
                                slot_next = free_slot;
                                state_next = ST_DIV;
                            end
                        end
                        satq_pkg::OP_CANCEL:
                        begin
                            ov_next = 1'b1;
                            ol_next = 1'b1;
                            od_next = {3'd0, !busy_reg[cslot], 16'd0, 4'(cslot)};
                            okind_next = satq_pkg::KIND_CANCEL;
                            if (busy_reg[cslot])
                            begin
                                cmd.remove_slot = 1'b1;
                                busy_next[cslot] = 1'b0;
                                pend_next = pend_reg - CW'(1);
                            end
                        end
                        satq_pkg::OP_TICK:
                        begin
                            count_next = count_reg + 64'd1;
                            fired_next = '0;
                            state_next = ST_FIRE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                cmd.insert = 1'b1;
                busy_next[slot_reg] = 1'b1;
                pend_next = pend_reg + CW'(1);
                ov_next = 1'b1;
                ol_next = 1'b1;
                od_next = {3'd0, 1'b0, 16'd0, 4'(slot_reg)};
                okind_next = satq_pkg::KIND_REGISTERED;
                state_next = ST_IDLE;
            end
            ST_FIRE:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    if (due && fired_reg != 5'd16)
                    begin
                        cmd.remove_head = 1'b1;
                        busy_next[head_entry.slot] = 1'b0;
                        pend_next = pend_reg - CW'(1);
                        fired_next = fired_reg + 5'd1;
                        ov_next = 1'b1;
                        ol_next = 1'b0;
                        od_next = {3'd0, 1'b0, head_entry.tag, 4'(head_entry.slot)};
                        okind_next = satq_pkg::KIND_FIRED;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                // Head now holds the next entry; decide whether the held word is last.
                if (!(due && fired_reg != 5'd16))
                begin
                    ol_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIRE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            period_reg <= 16'd10;
            count_reg <= '0;
            busy_reg <= '0;
            pend_reg <= '0;
            fired_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            fired_reg <= fired_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        slot_reg <= slot_next;
        od_reg <= od_next;
        okind_reg <= okind_next;
        ol_reg <= ol_next;
    end
endmodule

// File: design/satq_cell.sv
// One cell of the sorted chain: holds one pending alarm.
module satq_cell (
    input  logic clk,
    input  logic rst_n,
    input  satq_pkg::cmd_t cmd,
    input  logic prev_valid,
    input  satq_pkg::entry_t prev_entry,
    input  logic prev_insert_here,
    input  logic prev_remove_before,
    input  logic next_valid,
    input  satq_pkg::entry_t next_entry,
    output logic valid,
    output satq_pkg::entry_t entry,
    output logic insert_here,
    output logic remove_before
);
    logic valid_reg, valid_next;
    satq_pkg::entry_t entry_reg, entry_next;
    logic after_ins, match;

    assign valid = valid_reg;
    assign entry = entry_reg;
    // New alarm goes in front of this cell when this cell is later than it.
    assign after_ins = valid_reg && (entry_reg.deadline > cmd.ins.deadline);
    assign insert_here = prev_insert_here || after_ins;
    assign match = valid_reg && (entry_reg.slot == cmd.rm_slot);
    assign remove_before = prev_remove_before || match;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (insert_here)
            begin
                if (prev_insert_here)
                begin
                    valid_next = prev_valid;
                    entry_next = prev_entry;
                end
                else
                begin
                    valid_next = 1'b1;
                    entry_next = cmd.ins;
                end
            end
            else if (!valid_reg && prev_valid)
            begin
                valid_next = 1'b1;
                entry_next = cmd.ins;
            end
        end
        else if (cmd.remove_head || (cmd.remove_slot && remove_before))
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end
endmodule

// File: design/satq_chain.sv
// Row of cells kept in ascending deadline order.
module satq_chain (
    input  logic clk,
    input  logic rst_n,
    input  satq_pkg::cmd_t cmd,
    output logic head_valid,
    output satq_pkg::entry_t head_entry
);
    localparam int N = satq_pkg::Capacity;
    logic [N:0] v;
    satq_pkg::entry_t e [N+1];
    logic [N:0] ih;
    logic [N:0] rb;

    assign v[N] = 1'b0;
    assign e[N] = '0;
    assign ih[0] = 1'b0;
    assign rb[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            satq_cell u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .cmd(cmd),
                .prev_valid((g == 0) ? 1'b1 : v[(g == 0) ? 0 : g-1]),
                .prev_entry(e[(g == 0) ? 0 : g-1]),
                .prev_insert_here(ih[g]),
                .prev_remove_before(rb[g]),
                .next_valid(v[g+1]),
                .next_entry(e[g+1]),
                .valid(v[g]),
                .entry(e[g]),
                .insert_here(ih[g+1]),
                .remove_before(rb[g+1])
            );
        end
    endgenerate

    assign head_valid = v[0];
    assign head_entry = e[0];
endmodule

// File: design/satq_divider.sv
// Restoring divider turning a delay in ms into ticks, one bit a cycle.
module satq_divider (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [32:0] dividend,
    input  logic [15:0] divisor,
    output logic done,
    output logic [32:0] quotient
);
    logic busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [32:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [17:0] trial;
    logic done_reg, done_next;

    assign done = done_reg;
    assign quotient = q_reg;
    assign trial = {r_reg, q_reg[32]} - {2'b00, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd33;
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                r_next = trial[16:0];
                q_next = {q_reg[31:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[15:0], q_reg[32]};
                q_next = {q_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule
